// File: rtl/nearest_facet_by_normal_macros.svh
// Assertion macros for the nearest facet search block.
// Used by nearest_facet_by_normal.sv; no other dependencies.
`ifndef NEAREST_FACET_BY_NORMAL_MACROS_SVH
`define NEAREST_FACET_BY_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
`define NFBN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NFBN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NFBN_ASSERT_NOW(lbl, ante, cons, msg)
`define NFBN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/nfbn_pkg.sv
// Shared constants and fixed-point helpers for the nearest facet search.
// No dependencies; used by nfbn_div, nearest_facet_by_normal and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package nfbn_pkg;
	localparam int MAX_FACETS_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int WORDS_PER_FACET = 12;
	localparam int DIV_W           = 64;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [1:0] CFG_FAR       = 2'd1;
	localparam logic [1:0] CFG_COUNT     = 2'd2;

	localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

	// clamp to a w-bit signed range, w <= 32
	function automatic logic signed [31:0] sat_val(input logic signed [63:0] v, input int w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) return hi[31:0];
		if (v < lo) return lo[31:0];
		return v[31:0];
	endfunction

	// signed quotient from an unsigned magnitude, clamped to w bits
	function automatic logic signed [63:0] sat_quot(input logic [63:0] q, input logic neg,
	                                                input int w);
		logic [63:0] lim;
		lim = 64'd1 << (w - 1);
		if (neg) return (q >= lim) ? -$signed(lim) : -$signed(q);
		return (q >= lim) ? $signed(lim - 64'd1) : $signed(q);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction
endpackage

`default_nettype wire

// File: rtl/nfbn_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nfbn_pkg (DIV_W).
`timescale 1ns / 1ps
`default_nettype none

module nfbn_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [nfbn_pkg::DIV_W-1:0] dividend,
	input  wire logic [nfbn_pkg::DIV_W-1:0] divisor,
	output logic      [nfbn_pkg::DIV_W-1:0] quotient,
	output logic                          done
);
	import nfbn_pkg::*;

	localparam int CNTW = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q, quo_q, div_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNTW'(DIV_W - 1));
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

`default_nettype wire

// File: rtl/nearest_facet_by_normal.sv
// Top level of the nearest facet search: facet store, sequencer, shared multiplier.
// Depends on nfbn_pkg, nfbn_div and nearest_facet_by_normal_macros.svh.
//
//  channel | signals                                              | moves
//  --------+------------------------------------------------------+---------------------
//  in      | in_valid/in_ready, mode, facet_index, word_select,   | load word or query
//          | word_value, point_x, point_y, point_z                |
//  out     | out_valid/out_ready, found, nearest_facet,           | one word per query
//          | inside_hit, nearest_distance                         |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data             | register write
//
// A load word goes straight into the store and the block stays ready. A query
// walks the facets once, and a second time if nothing was inside. Per facet:
// read its 12 words from the store, the normal distance, then in pass one for
// a facet that may win: projection, determinants and two 64-step divides.
// No clearing pass after reset. A finished word waits in the output register;
// a new item is taken meanwhile, and the next result waits for out_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_facet_by_normal_macros.svh"

module nearest_facet_by_normal #(
	parameter int MAX_FACETS  = nfbn_pkg::MAX_FACETS_DEF,
	parameter int VALUE_WIDTH = nfbn_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire logic [9:0]         facet_index,
	input  wire logic [3:0]         word_select,
	input  wire logic signed [31:0] word_value,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    found,
	output logic [9:0]              nearest_facet,
	output logic                    inside_hit,
	output logic [30:0]             nearest_distance,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import nfbn_pkg::*;

	localparam int VW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int DEPTH = MAX_FACETS * WORDS_PER_FACET;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
	localparam int CW    = $clog2(MAX_FACETS + 1);

	// sequencer steps inside CALC
	localparam logic [4:0] S_DX    = 5'd0;
	localparam logic [4:0] S_DY    = 5'd1;
	localparam logic [4:0] S_DZ    = 5'd2;
	localparam logic [4:0] S_DSUM  = 5'd3;
	localparam logic [4:0] S_CHECK = 5'd4;
	localparam logic [4:0] S_PY    = 5'd5;
	localparam logic [4:0] S_PZ    = 5'd6;
	localparam logic [4:0] S_PZQ   = 5'd7;
	localparam logic [4:0] S_PLANE = 5'd8;
	localparam logic [4:0] S_M1    = 5'd9;
	localparam logic [4:0] S_M2    = 5'd10;
	localparam logic [4:0] S_M3    = 5'd11;
	localparam logic [4:0] S_M4    = 5'd12;
	localparam logic [4:0] S_M5    = 5'd13;
	localparam logic [4:0] S_M6    = 5'd14;
	localparam logic [4:0] S_N2    = 5'd15;
	localparam logic [4:0] S_DIVGO = 5'd16;

	localparam logic [3:0] LAST_WORD = 4'(WORDS_PER_FACET);

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_CALC, ST_DIV1, ST_DIV2, ST_TEST, ST_NEXT, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [30:0] tolerance_q, far_q;
	logic [10:0] count_q;

	// facet store
	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               wr_en, rd_en;

	// query datapath
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] w_q [WORDS_PER_FACET];
	logic signed [31:0] qx_q, qy_q, qz_q;
	logic signed [31:0] a13_q, a23_q, a3i_q, b13_q, b23_q, b3i_q;
	logic signed [63:0] prod_q, acc_q, d_q, den_q, n1_q, n2_q, l1_q, l2_q;
	logic [30:0]        best_q;
	logic [FW-1:0]      pick_q;
	logic [CW-1:0]      f_q, nf_q;
	logic [AW-1:0]      base_q;
	logic [3:0]         k_q;
	logic [4:0]         st_q;
	logic               pass_q, found_q, inside_q, div_go_q;

	// output word
	logic        out_valid_q, found_out_q, inside_out_q;
	logic [9:0]  facet_out_q;
	logic [30:0] dist_out_q;

	// combinational helpers
	logic signed [31:0] mul_a, mul_b, dx, dy, dz, d32;
	logic signed [63:0] fl, l3, neg_eps, eps64;
	logic [63:0]        d_mag;
	logic [32:0]        nx_mag, ny_mag;
	logic signed [31:0] sa1, sa2, sa3, sai, sb1, sb2, sb3, sbi;
	logic [DIV_W-1:0]   div_dividend, div_divisor, div_quot;
	logic               div_done, div_neg;
	logic [CW-1:0]      f_inc, nf_new;
	logic               in_fire, cfg_fire, out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign wr_en   = in_fire && (mode == MODE_LOAD) && (word_select < LAST_WORD) &&
	                 (32'(facet_index) < 32'(MAX_FACETS));
	assign wr_addr = AW'({facet_index, 3'b000}) + AW'({facet_index, 2'b00}) + AW'(word_select);
	assign rd_en   = (state_q == ST_FETCH) && (k_q < LAST_WORD);
	assign rd_addr = base_q + AW'(k_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sat_val(64'(word_value), VW);
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		fl      = prod_q >>> 16;
		dx      = sat_val(64'(px_q) - 64'(w_q[0]), VW);
		dy      = sat_val(64'(py_q) - 64'(w_q[1]), VW);
		dz      = sat_val(64'(pz_q) - 64'(w_q[2]), VW);
		d32     = d_q[31:0];
		d_mag   = mag64(d_q);
		eps64   = $signed({33'b0, tolerance_q});
		neg_eps = -eps64;
		nx_mag  = (w_q[9] < 0) ? 33'(-33'(w_q[9])) : 33'(w_q[9]);
		ny_mag  = (w_q[10] < 0) ? 33'(-33'(w_q[10])) : 33'(w_q[10]);
		l3      = ONE_Q16 - l1_q - l2_q;
		f_inc   = f_q + 1'b1;
		nf_new  = (32'(count_q) > 32'(MAX_FACETS)) ? CW'(MAX_FACETS) : CW'(count_q);

		unique case (st_q)
			S_DX:    begin mul_a = w_q[9];  mul_b = dx;    end
			S_DY:    begin mul_a = w_q[10]; mul_b = dy;    end
			S_DZ:    begin mul_a = w_q[11]; mul_b = dz;    end
			S_CHECK: begin mul_a = d32;     mul_b = w_q[9];  end
			S_PY:    begin mul_a = d32;     mul_b = w_q[10]; end
			S_PZ:    begin mul_a = d32;     mul_b = w_q[11]; end
			S_M1:    begin mul_a = b23_q;   mul_b = a13_q; end
			S_M2:    begin mul_a = a23_q;   mul_b = b13_q; end
			S_M3:    begin mul_a = a23_q;   mul_b = b3i_q; end
			S_M4:    begin mul_a = b23_q;   mul_b = a3i_q; end
			S_M5:    begin mul_a = b13_q;   mul_b = a3i_q; end
			S_M6:    begin mul_a = a13_q;   mul_b = b3i_q; end
			default: begin mul_a = '0;      mul_b = '0;    end
		endcase

		// plane pick: yz, then zx, then xy
		priority if (nx_mag > {2'b0, tolerance_q}) begin
			sa1 = w_q[1]; sa2 = w_q[4]; sa3 = w_q[7]; sai = qy_q;
			sb1 = w_q[2]; sb2 = w_q[5]; sb3 = w_q[8]; sbi = qz_q;
		end else if (ny_mag > {2'b0, tolerance_q}) begin
			sa1 = w_q[2]; sa2 = w_q[5]; sa3 = w_q[8]; sai = qz_q;
			sb1 = w_q[0]; sb2 = w_q[3]; sb3 = w_q[6]; sbi = qx_q;
		end else begin
			sa1 = w_q[0]; sa2 = w_q[3]; sa3 = w_q[6]; sai = qx_q;
			sb1 = w_q[1]; sb2 = w_q[4]; sb3 = w_q[7]; sbi = qy_q;
		end

		div_dividend = (state_q == ST_DIV2) ? (mag64(n2_q) << 16) : (mag64(n1_q) << 16);
		div_divisor  = mag64(den_q);
		div_neg      = (state_q == ST_DIV2) ? ((n2_q < 0) != (den_q < 0)) :
		                                      ((n1_q < 0) != (den_q < 0));
	end

	nfbn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tolerance_q  <= 31'd66;
			far_q        <= 31'h7FFF_FFFF;
			count_q      <= '0;
			px_q         <= '0;
			py_q         <= '0;
			pz_q         <= '0;
			for (int i = 0; i < WORDS_PER_FACET; i++) w_q[i] <= '0;
			qx_q         <= '0;
			qy_q         <= '0;
			qz_q         <= '0;
			a13_q        <= '0;
			a23_q        <= '0;
			a3i_q        <= '0;
			b13_q        <= '0;
			b23_q        <= '0;
			b3i_q        <= '0;
			prod_q       <= '0;
			acc_q        <= '0;
			d_q          <= '0;
			den_q        <= '0;
			n1_q         <= '0;
			n2_q         <= '0;
			l1_q         <= '0;
			l2_q         <= '0;
			best_q       <= '0;
			pick_q       <= '0;
			f_q          <= '0;
			nf_q         <= '0;
			base_q       <= '0;
			k_q          <= '0;
			st_q         <= S_DX;
			pass_q       <= 1'b0;
			found_q      <= 1'b0;
			inside_q     <= 1'b0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			found_out_q  <= 1'b0;
			inside_out_q <= 1'b0;
			facet_out_q  <= '0;
			dist_out_q   <= '0;
		end else begin
			// start the first divide on a good facet, the second when the first ends
			div_go_q <= ((state_q == ST_CALC) && (st_q == S_DIVGO) && (den_q != 0)) ||
			            ((state_q == ST_DIV1) && div_done);
			prod_q   <= 64'(mul_a) * 64'(mul_b);
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_TOLERANCE: tolerance_q <= cfg_data[30:0];
					CFG_FAR:       far_q       <= cfg_data[30:0];
					CFG_COUNT:     count_q     <= cfg_data[10:0];
					default:       ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && mode == MODE_QUERY) begin
						px_q     <= sat_val(64'(point_x), VW);
						py_q     <= sat_val(64'(point_y), VW);
						pz_q     <= sat_val(64'(point_z), VW);
						best_q   <= far_q;
						pick_q   <= '0;
						nf_q     <= nf_new;
						f_q      <= '0;
						base_q   <= '0;
						k_q      <= '0;
						pass_q   <= 1'b0;
						found_q  <= 1'b0;
						inside_q <= 1'b0;
						state_q  <= (nf_new == '0) ? ST_DONE : ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (k_q != '0) begin
						w_q[k_q - 1'b1] <= rd_q;
					end
					if (k_q == LAST_WORD) begin
						k_q     <= '0;
						st_q    <= S_DX;
						state_q <= ST_CALC;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_CALC: begin
					st_q <= st_q + 1'b1;
					unique case (st_q)
						S_DY:    acc_q <= fl;
						S_DZ:    acc_q <= acc_q + fl;
						S_DSUM:  d_q   <= acc_q + fl;
						S_CHECK: begin
							if (pass_q) begin
								if (!(d_q > eps64) && d_mag < 64'(best_q)) begin
									best_q  <= d_mag[30:0];
									pick_q  <= f_q[FW-1:0];
									found_q <= 1'b1;
								end
								state_q <= ST_NEXT;
							end else if (d_q > 0 || d_mag >= 64'(best_q)) begin
								state_q <= ST_NEXT;
							end
						end
						S_PY:    qx_q <= sat_val(64'(px_q) - fl, VW);
						S_PZ:    qy_q <= sat_val(64'(py_q) - fl, VW);
						S_PZQ:   qz_q <= sat_val(64'(pz_q) - fl, VW);
						S_PLANE: begin
							a13_q <= sat_val(64'(sa1) - 64'(sa3), VW);
							a23_q <= sat_val(64'(sa2) - 64'(sa3), VW);
							a3i_q <= sat_val(64'(sa3) - 64'(sai), VW);
							b13_q <= sat_val(64'(sb1) - 64'(sb3), VW);
							b23_q <= sat_val(64'(sb2) - 64'(sb3), VW);
							b3i_q <= sat_val(64'(sb3) - 64'(sbi), VW);
						end
						S_M2:    acc_q <= fl;
						S_M3:    den_q <= acc_q - fl;
						S_M4:    acc_q <= fl;
						S_M5:    n1_q  <= acc_q - fl;
						S_M6:    acc_q <= fl;
						S_N2:    n2_q  <= acc_q - fl;
						S_DIVGO: begin
							if (den_q == 0) begin
								state_q <= ST_NEXT;
							end else begin
								state_q <= ST_DIV1;
							end
						end
						default: ;
					endcase
				end
				ST_DIV1: begin
					if (div_done) begin
						l1_q    <= sat_quot(div_quot, div_neg, VW);
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						l2_q    <= sat_quot(div_quot, div_neg, VW);
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (l1_q > neg_eps && l2_q > neg_eps && l3 > neg_eps) begin
						best_q   <= d_mag[30:0];
						pick_q   <= f_q[FW-1:0];
						found_q  <= 1'b1;
						inside_q <= 1'b1;
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					k_q <= '0;
					if (f_inc == nf_q) begin
						if (!pass_q && !found_q) begin
							pass_q  <= 1'b1;
							f_q     <= '0;
							base_q  <= '0;
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						f_q     <= f_inc;
						base_q  <= base_q + AW'(WORDS_PER_FACET);
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						found_out_q  <= found_q;
						inside_out_q <= inside_q;
						facet_out_q  <= found_q ? 10'(pick_q) : 10'd0;
						dist_out_q   <= found_q ? best_q : 31'd0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_out_q;
	assign inside_hit       = inside_out_q;
	assign nearest_facet    = facet_out_q;
	assign nearest_distance = dist_out_q;

	`NFBN_ASSERT_NOW(a_div_nonzero, (state_q == ST_DIV1 || state_q == ST_DIV2), (den_q != 0), "divide started on a degenerate facet")
	`NFBN_ASSERT_NOW(a_facet_range, (state_q == ST_FETCH || state_q == ST_CALC), (f_q < nf_q), "facet counter past the facet count")
	`NFBN_ASSERT_NOW(a_miss_zero, (out_valid_q && !found_out_q), (facet_out_q == '0 && dist_out_q == '0 && !inside_out_q), "miss word carries nonzero fields")
	`NFBN_ASSERT_NEXT(a_best_shrinks, (state_q != ST_IDLE && state_q != ST_DONE), (best_q <= $past(best_q)), "best distance grew during a search")
	`NFBN_ASSERT_NOW(a_inside_pass, (inside_q), (found_q && !pass_q), "inside hit outside pass one")

endmodule

`default_nettype wire

// File: tb/nearest_facet_by_normal_test.sv
// Testbench for nearest_facet_by_normal: loads facet tables, runs point queries
// and checks each result against an in-bench model. Depends on nfbn_pkg and the RTL.
`timescale 1ns / 1ps

module nearest_facet_by_normal_test;
	import nfbn_pkg::*;

	localparam int NFAC = 1024;
	localparam int WPF = 12;
	localparam logic [3:0] WS_X1 = 4'd0;
	localparam logic [3:0] WS_NX = 4'd9;
	localparam logic [3:0] WS_NY = 4'd10;
	localparam logic [3:0] WS_NZ = 4'd11;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam longint ONE = 65536;
	localparam int IDLE_PCT = 17;

	typedef struct {
		logic found;
		logic [9:0] facet;
		logic in_facet;
		logic [30:0] distance;
	} hit_t;

	logic clk, arst_n;
	logic in_valid, in_ready, mode;
	logic [9:0] facet_index;
	logic [3:0] word_select;
	logic signed [31:0] word_value, point_x, point_y, point_z;
	logic out_valid, out_ready, found, inside_hit;
	logic [9:0] nearest_facet;
	logic [30:0] nearest_distance;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	// model state
	int facet_mem [NFAC*WPF];
	longint unsigned tol, far_dist, count;
	hit_t hit_q[$];
	int errors;
	int hold_left;
	bit no_idle;

	nearest_facet_by_normal u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.facet_index(facet_index), .word_select(word_select), .word_value(word_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .found(found),
		.nearest_facet(nearest_facet), .inside_hit(inside_hit),
		.nearest_distance(nearest_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("nearest_facet_by_normal_test NOT OK");
		$finish;
	end

	// ---------------- fixed-point predictor ----------------
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fmul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	function automatic longint absl(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint fdiv(longint n, longint d);
		longint unsigned q;
		longint unsigned lim;
		lim = 64'd1 << 31;
		q = (longint'(absl(n)) << 16) / longint'(absl(d));
		if ((n < 0) != (d < 0)) return (q >= lim) ? -longint'(lim) : -longint'(q);
		return (q >= lim) ? longint'(lim - 1) : longint'(q);
	endfunction

	function automatic bit bary_inside(longint a1, longint a2, longint a3, longint ai,
	                                   longint b1, longint b2, longint b3, longint bi,
	                                   longint eps);
		longint a13, a23, a3i, b13, b23, b3i, den, n1, n2, l1, l2, l3;
		a13 = clamp32(a1 - a3); a23 = clamp32(a2 - a3); a3i = clamp32(a3 - ai);
		b13 = clamp32(b1 - b3); b23 = clamp32(b2 - b3); b3i = clamp32(b3 - bi);
		den = fmul(b23, a13) - fmul(a23, b13);
		n1 = fmul(a23, b3i) - fmul(b23, a3i);
		n2 = fmul(b13, a3i) - fmul(a13, b3i);
		if (den == 0) return 1'b0;
		l1 = fdiv(n1, den);
		l2 = fdiv(n2, den);
		l3 = ONE - l1 - l2;
		return (l1 > -eps) && (l2 > -eps) && (l3 > -eps);
	endfunction

	function automatic longint fw(int f, int k);
		return longint'(facet_mem[f*WPF + k]);
	endfunction

	function automatic longint plane_dist(int f, longint p[3]);
		longint s;
		s = 0;
		for (int a = 0; a < 3; a++)
			s += fmul(fw(f, 9 + a), clamp32(p[a] - fw(f, a)));
		return s;
	endfunction

	function automatic hit_t nearest_hit(longint px, longint py, longint pz);
		longint p[3], q[3], d, best, eps;
		int nf, pick;
		bit ok, hit, ins;
		hit_t r;
		p[0] = px; p[1] = py; p[2] = pz;
		eps = longint'(tol);
		best = longint'(far_dist);
		nf = (count > NFAC) ? NFAC : int'(count);
		pick = 0; hit = 0; ins = 0;
		for (int f = 0; f < nf; f++) begin
			d = plane_dist(f, p);
			if (d > 0 || absl(d) >= best) continue;
			for (int a = 0; a < 3; a++) q[a] = clamp32(p[a] - fmul(d, fw(f, 9 + a)));
			if (absl(fw(f, 9)) > eps)
				ok = bary_inside(fw(f,1), fw(f,4), fw(f,7), q[1],
				                 fw(f,2), fw(f,5), fw(f,8), q[2], eps);
			else if (absl(fw(f, 10)) > eps)
				ok = bary_inside(fw(f,2), fw(f,5), fw(f,8), q[2],
				                 fw(f,0), fw(f,3), fw(f,6), q[0], eps);
			else
				ok = bary_inside(fw(f,0), fw(f,3), fw(f,6), q[0],
				                 fw(f,1), fw(f,4), fw(f,7), q[1], eps);
			if (ok) begin
				best = absl(d); pick = f; hit = 1; ins = 1;
			end
		end
		if (!hit) begin
			// fallback: nearest facet not more than the tolerance above its plane
			for (int f = 0; f < nf; f++) begin
				d = plane_dist(f, p);
				if (d > eps) continue;
				if (absl(d) < best) begin
					best = absl(d); pick = f; hit = 1;
				end
			end
		end
		r.found = hit;
		r.facet = hit ? pick[9:0] : 10'd0;
		r.in_facet = ins;
		r.distance = hit ? best[30:0] : 31'd0;
		return r;
	endfunction

	// ---------------- stimulus ----------------
	task automatic send_item(logic m, logic [9:0] fi, logic [3:0] ws, logic [31:0] wv,
	                         logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		if (!no_idle)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		in_valid = 1'b1;
		mode = m; facet_index = fi; word_select = ws; word_value = wv;
		point_x = px; point_y = py; point_z = pz;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_LOAD) begin
			if (ws < WPF) facet_mem[int'(fi)*WPF + ws] = wv;
		end else
			hit_q.push_back(nearest_hit(longint'($signed(px)), longint'($signed(py)),
			                            longint'($signed(pz))));
		@(negedge clk);
	endtask

	task automatic load_word(int f, int k, longint v);
		send_item(MODE_LOAD, f[9:0], k[3:0], v[31:0], $urandom, $urandom, $urandom);
	endtask

	task automatic query(longint x, longint y, longint z);
		send_item(MODE_QUERY, 10'($urandom), 4'($urandom), $urandom,
		          x[31:0], y[31:0], z[31:0]);
	endtask

	task automatic load_facet(int f, longint v[12]);
		for (int k = 0; k < WPF; k++) load_word(f, k, v[k]);
	endtask

	// wait for the block to go quiet; loads give no result, so pad with idle cycles
	task automatic drain();
		in_valid = 1'b0;
		while (hit_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		drain();
		cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TOLERANCE: tol = data[30:0];
			CFG_FAR:       far_dist = data[30:0];
			CFG_COUNT:     count = data[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic longint rnd_small(longint span);
		return longint'($urandom_range(32'(2*span))) - span;
	endfunction

	task automatic rand_facet(int f);
		longint v[12];
		for (int k = 0; k < 9; k++) v[k] = rnd_small(4*65536);
		for (int k = 9; k < 12; k++) v[k] = rnd_small(65536);
		// sometimes flatten a normal component so the other planes get picked
		if ($urandom_range(2) == 0) v[WS_NX] = rnd_small(40);
		if ($urandom_range(3) == 0) v[WS_NY] = rnd_small(40);
		load_facet(f, v);
	endtask

	// ---------------- tests ----------------
	task automatic test_empty_table();
		query(0, 0, 0);
		write_reg(CFG_COUNT, 0);
		query(32'h7fffffff, 32'h80000000, 32'h7fffffff);
	endtask

	task automatic test_directed();
		longint xy[12] = '{0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, ONE};
		longint yz[12] = '{0, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, ONE, 0, 0};
		longint zx[12] = '{0, 0, 0, 0, 0, 2*ONE, 2*ONE, 0, 0, 0, ONE, 0};
		longint flat[12] = '{0, 0, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0, 0, 0, ONE};
		load_facet(0, xy);
		load_facet(1, yz);
		load_facet(2, zx);
		load_facet(3, flat);
		load_facet(4, xy); // duplicate of facet 0: tie must pick index 0
		for (int ws = 12; ws < 16; ws++) load_word(0, ws, 32'h12345678);
		load_word(1023, WS_X1, 32'h80000000);
		load_word(1023, WS_NZ, 32'h7fffffff);
		write_reg(CFG_COUNT, 5);
		query(ONE/2, ONE/2, -ONE);       // inside xy facet below the plane
		query(-ONE, ONE/2, ONE/2);       // inside yz facet
		query(ONE/2, -ONE, ONE/2);       // inside zx facet
		query(3*ONE, 3*ONE, 0);          // on planes but outside: fallback
		query(ONE, ONE, ONE);            // above every plane
		query(32'h80000000, 32'h80000000, 32'h80000000);
		query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		write_reg(CFG_FAR, 100);
		query(ONE/2, ONE/2, -ONE);       // farther than start distance
		write_reg(CFG_TOLERANCE, 32'hffffffff);
		query(3*ONE, 3*ONE, ONE);
		write_reg(CFG_TOLERANCE, 0);
		write_reg(CFG_FAR, 32'h7fffffff);
		query(ONE/4, ONE/4, -ONE/8);
		write_reg(CFG_UNUSED, 32'hffffffff);
		write_reg(CFG_TOLERANCE, 66);
		query(0, 0, 0);
	endtask

	// facets 0..4 start as the directed test left them; one is redrawn per phase
	task automatic test_random();
		int nf, n, fi;
		for (int ph = 0; ph < 2; ph++) begin
			fi = $urandom_range(4);
			no_idle = (ph == 1);
			rand_facet(fi);
			nf = $urandom_range(1, 5);
			write_reg(CFG_COUNT, nf);
			write_reg(CFG_TOLERANCE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000));
			write_reg(CFG_FAR, ($urandom_range(2) == 0) ? $urandom_range(32'(8*ONE)) :
			                                              32'h7fffffff);
			n = 0;
			while (n < 8) begin
				case ($urandom_range(9))
					0: query($urandom, $urandom, $urandom);
					1: load_word($urandom_range(nf - 1), $urandom_range(11), rnd_small(4*ONE));
					2: load_word($urandom_range(nf, 1023), $urandom_range(15),
					             longint'($urandom));
					default: query(rnd_small(4*ONE), rnd_small(4*ONE), rnd_small(4*ONE));
				endcase
				n++;
			end
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		write_reg(CFG_COUNT, 1);
		no_idle = 1;
		hold_left = 1500;
		for (int i = 0; i < 6; i++) query(rnd_small(2*ONE), rnd_small(2*ONE), rnd_small(2*ONE));
		no_idle = 0;
	endtask

	// ---------------- result side ----------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else
			out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && out_valid && out_ready) begin
			if (hit_q.size() == 0) begin
				$display("%t unexpected word: found=%0d facet=%0d inside=%0d dist=%0d",
				         $time, found, nearest_facet, inside_hit, nearest_distance);
				errors++;
			end else begin
				e = hit_q.pop_front();
				if (found !== e.found) begin
					$display("%t found: expected %0d actual %0d", $time, e.found, found);
					errors++;
				end
				if (nearest_facet !== e.facet) begin
					$display("%t nearest_facet: expected %0d actual %0d",
					         $time, e.facet, nearest_facet);
					errors++;
				end
				if (inside_hit !== e.in_facet) begin
					$display("%t inside_hit: expected %0d actual %0d",
					         $time, e.in_facet, inside_hit);
					errors++;
				end
				if (nearest_distance !== e.distance) begin
					$display("%t nearest_distance: expected %0d actual %0d",
					         $time, e.distance, nearest_distance);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0; hold_left = 0; no_idle = 0;
		tol = 66; far_dist = 32'h7fffffff; count = 0;
		foreach (facet_mem[i]) facet_mem[i] = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; mode = MODE_LOAD; facet_index = '0; word_select = '0;
		word_value = '0; point_x = '0; point_y = '0; point_z = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_TOLERANCE; cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_table();
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("nearest_facet_by_normal_test OK");
		else
			$display("nearest_facet_by_normal_test NOT OK");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/nfbn_pkg.sv
rtl/nfbn_div.sv
rtl/nearest_facet_by_normal.sv
tb/nearest_facet_by_normal_test.sv
